[design/tlv_chunk_field_extractor_defines.svh]
// assertion macros for the port-level checker
`ifndef TLV_CHUNK_FIELD_EXTRACTOR_DEFINES_SVH
`define TLV_CHUNK_FIELD_EXTRACTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TLV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/tlv_cfe_pkg.sv]
// shared constants and types for the tlv chunk field extractor
package tlv_cfe_pkg;

	localparam int POS_BITS = 20;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// result status codes
	localparam logic [1:0] ST_NOT_FOUND  = 2'd0;
	localparam logic [1:0] ST_FOUND      = 2'd1;
	localparam logic [1:0] ST_NO_EXTRACT = 2'd2;
	localparam logic [1:0] ST_MALFORMED  = 2'd3;

	// chunk types with field extraction
	localparam logic [15:0] TYPE_A = 16'd2;
	localparam logic [15:0] TYPE_B = 16'd7;

	// bytes a matched chunk must hold for extraction
	localparam logic [15:0] EXTENT_A = 16'h0021;
	localparam logic [15:0] EXTENT_B = 16'h0016;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 96;

	typedef struct packed {
		logic [1:0]          status;
		logic [15:0]         field_a;
		logic [15:0]         field_b;
		logic [15:0]         field_c;
		logic [15:0]         extra_short;
		logic [7:0]          extra_word;
		logic [POS_BITS-1:0] next_offset;
	} result_t;

endpackage

[design/tlv_chunk_field_extractor.sv]
// top level: tlv chunk walker with fixed field capture for a matched chunk
//
//  channel   | signals                          | content
//  ----------+----------------------------------+-----------------------------------
//  s_ (in)   | s_tvalid s_tready s_tdata s_tuser| one buffer byte, start flag
//  m_ (out)  | m_tvalid m_tready m_tdata m_tuser| at most one result per search, status
//  cfg       | cfg_wr_en cfg_wr_data            | match_type register
//
// one byte per cycle while the input does not stall; a transfer lands in the input stage
// register, is processed in the next cycle and its result (if any) is then loaded into the
// output register, which drives m_tvalid. the input stalls only when the staged byte
// produces a result while the output register still holds an untaken one.
// arst_n clears all control and search state; the block idles until a byte
// with the start flag arrives.
module tlv_chunk_field_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tlv_cfe_pkg::IN_DATA_W-1:0] s_tdata,  // [7:0] byte_value
	input  logic                              s_tuser,  // [0] start_of_buffer
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] field_a, [31:16] field_b, [47:32] field_c, [63:48] extra_short,
	// [71:64] extra_word, [91:72] next_offset, [95:92] zero
	output logic [tlv_cfe_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                        m_tuser,  // [1:0] status
	input  logic                              cfg_wr_en,
	input  logic [15:0]                       cfg_wr_data
);

	localparam int PW = tlv_cfe_pkg::POS_BITS;

	// configuration
	logic [15:0] match_type_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// search state
	logic [15:0]   cpos_q;
	logic [15:0]   clen_q;
	logic [15:0]   ctype_q;
	logic [PW-1:0] bpos_q;
	logic [15:0]   fld0_q, fld1_q, fld2_q, fld3_q;
	logic [7:0]    xbyte_q;
	logic [7:0]    sum_hi_q;
	logic [8:0]    sum_lo_q;
	logic          matched_q;
	logic          done_q;

	// output register
	logic                         out_valid_q;
	tlv_cfe_pkg::result_t         out_q;

	// effective state after a possible start clear
	logic [15:0]   p, clen, ctype;
	logic [PW-1:0] bpos;
	logic          matched;
	logic          active;
	logic          go;
	logic          upd;

	// next values
	logic [15:0]   clen_n, ctype_n, cpos_n;
	logic [15:0]   fld0_n, fld1_n, fld2_n, fld3_n;
	logic [7:0]    xbyte_n, sum_hi_n;
	logic [8:0]    sum_lo_n;
	logic          matched_n;
	logic [PW-1:0] bpos_n;

	logic [PW-1:0] chunk_start;
	logic [PW:0]   end_sum;
	logic [PW-1:0] end_sat;
	logic [15:0]   extent;
	logic [16:0]   p_inc;

	logic          emit;
	tlv_cfe_pkg::result_t res;

	assign active = valid_s1 && (start_s1 || !done_q);
	assign go     = !(active && emit) || !out_valid_q || m_tready;
	assign upd    = active && go;

	assign s_tready = !valid_s1 || go;

	always_comb begin
		p       = start_s1 ? 16'd0 : cpos_q;
		clen    = start_s1 ? 16'd0 : clen_q;
		ctype   = start_s1 ? 16'd0 : ctype_q;
		bpos    = start_s1 ? '0 : bpos_q;
		matched = start_s1 ? 1'b0 : matched_q;

		// offset of the chunk now being walked
		chunk_start = (bpos >= PW'(p)) ? bpos - PW'(p) : '0;
		// offset just past the chunk, saturated
		end_sum = {1'b0, chunk_start} + (PW+1)'(clen);
		end_sat = (end_sum > {1'b0, tlv_cfe_pkg::POS_MAX}) ? tlv_cfe_pkg::POS_MAX
			: end_sum[PW-1:0];
		extent = (ctype == tlv_cfe_pkg::TYPE_A) ? tlv_cfe_pkg::EXTENT_A
			: tlv_cfe_pkg::EXTENT_B;

		clen_n    = clen;
		ctype_n   = ctype;
		matched_n = matched;
		fld0_n    = start_s1 ? 16'd0 : fld0_q;
		fld1_n    = start_s1 ? 16'd0 : fld1_q;
		fld2_n    = start_s1 ? 16'd0 : fld2_q;
		fld3_n    = start_s1 ? 16'd0 : fld3_q;
		xbyte_n   = start_s1 ? 8'd0 : xbyte_q;
		sum_hi_n  = start_s1 ? 8'd0 : sum_hi_q;
		sum_lo_n  = start_s1 ? 9'd0 : sum_lo_q;

		emit = 1'b0;
		res  = '0;

		if (p == 16'd0) begin
			clen_n = {byte_s1, 8'h00};
		end else if (p == 16'd1) begin
			clen_n = {clen[15:8], byte_s1};
			if (clen_n == 16'd0) begin
				emit = 1'b1;
				res.status = tlv_cfe_pkg::ST_NOT_FOUND;
				res.next_offset = chunk_start;
			end else if (clen_n < 16'd4) begin
				emit = 1'b1;
				res.status = tlv_cfe_pkg::ST_MALFORMED;
				res.next_offset = chunk_start;
			end
		end else if (p == 16'd2) begin
			ctype_n = {byte_s1, 8'h00};
		end else if (p == 16'd3) begin
			ctype_n = {ctype[15:8], byte_s1};
			if (ctype_n == match_type_q) begin
				if (ctype_n == tlv_cfe_pkg::TYPE_A || ctype_n == tlv_cfe_pkg::TYPE_B) begin
					// extent of the newly known type
					if (clen < ((ctype_n == tlv_cfe_pkg::TYPE_A) ? tlv_cfe_pkg::EXTENT_A
						: tlv_cfe_pkg::EXTENT_B)) begin
						emit = 1'b1;
						res.status = tlv_cfe_pkg::ST_MALFORMED;
						res.next_offset = chunk_start;
					end else begin
						matched_n = 1'b1;
					end
				end else begin
					emit = 1'b1;
					res.status = tlv_cfe_pkg::ST_NO_EXTRACT;
					res.next_offset = end_sat;
				end
			end
		end else if (matched) begin
			if (ctype == tlv_cfe_pkg::TYPE_A) begin
				case (p)
					16'h000E: fld0_n[15:8] = byte_s1;
					16'h000F: fld0_n[7:0]  = byte_s1;
					16'h0010: fld1_n[15:8] = byte_s1;
					16'h0011: fld1_n[7:0]  = byte_s1;
					16'h0014, 16'h0016: sum_hi_n = sum_hi_n + byte_s1;
					16'h0015, 16'h0017: sum_lo_n = sum_lo_n + 9'(byte_s1);
					16'h001A: fld2_n[15:8] = byte_s1;
					16'h001B: fld2_n[7:0]  = byte_s1;
					16'h0020: xbyte_n = {7'd0, ~byte_s1[0]};
					default: ;
				endcase
				// short field from the two byte sums, bit 8 of the low sum overlaps
				fld3_n = {sum_hi_n, 8'h00} | {7'd0, sum_lo_n};
			end else begin
				case (p)
					16'h0004: fld0_n[15:8] = byte_s1;
					16'h0005: fld0_n[7:0]  = byte_s1;
					16'h0006: fld2_n[15:8] = byte_s1;
					16'h0007: fld2_n[7:0]  = byte_s1;
					16'h000C: fld1_n[15:8] = byte_s1;
					16'h000D: fld1_n[7:0]  = byte_s1;
					16'h000E: fld3_n[15:8] = byte_s1;
					16'h000F: fld3_n[7:0]  = byte_s1;
					16'h0015: xbyte_n = byte_s1;
					default: ;
				endcase
			end
			if (p == extent - 16'd1) begin
				emit = 1'b1;
				res.status      = tlv_cfe_pkg::ST_FOUND;
				res.field_a     = fld0_n;
				res.field_b     = fld1_n;
				res.field_c     = fld2_n;
				res.extra_short = fld3_n;
				res.extra_word  = xbyte_n;
				res.next_offset = end_sat;
			end
		end

		// advance within the chunk or wrap to the next chunk header
		p_inc = {1'b0, p} + 17'd1;
		cpos_n = p_inc[15:0];
		if (!emit && p >= 16'd3 && p_inc >= {1'b0, clen}) begin
			cpos_n    = 16'd0;
			matched_n = 1'b0;
		end

		bpos_n = (bpos == tlv_cfe_pkg::POS_MAX) ? bpos : bpos + PW'(1);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_type_q <= 16'd0;
		end else if (cfg_wr_en) begin
			match_type_q <= cfg_wr_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[7:0];
			start_s1 <= s_tuser;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpos_q    <= 16'd0;
			clen_q    <= 16'd0;
			ctype_q   <= 16'd0;
			bpos_q    <= '0;
			fld0_q    <= 16'd0;
			fld1_q    <= 16'd0;
			fld2_q    <= 16'd0;
			fld3_q    <= 16'd0;
			xbyte_q   <= 8'd0;
			sum_hi_q  <= 8'd0;
			sum_lo_q  <= 9'd0;
			matched_q <= 1'b0;
			done_q    <= 1'b1;
		end else if (upd) begin
			// position holds once a result ends the search
			if (!emit) begin
				cpos_q <= cpos_n;
			end else if (start_s1) begin
				cpos_q <= 16'd0;
			end
			clen_q    <= clen_n;
			ctype_q   <= ctype_n;
			bpos_q    <= bpos_n;
			fld0_q    <= fld0_n;
			fld1_q    <= fld1_n;
			fld2_q    <= fld2_n;
			fld3_q    <= fld3_n;
			xbyte_q   <= xbyte_n;
			sum_hi_q  <= sum_hi_n;
			sum_lo_q  <= sum_lo_n;
			matched_q <= matched_n;
			done_q    <= emit;
		end
	end

	// output register, reloads in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {4'd0, out_q.next_offset, out_q.extra_word, out_q.extra_short,
		out_q.field_c, out_q.field_b, out_q.field_a};

endmodule

[design/tlv_cfe_checker.sv]
// port-level checker for the tlv chunk field extractor, bound to the top level
`include "tlv_chunk_field_extractor_defines.svh"

module tlv_cfe_port_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [tlv_cfe_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                               s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [tlv_cfe_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                         m_tuser,
	input logic                               cfg_wr_en,
	input logic [15:0]                        cfg_wr_data
);

	// a stalled result holds
	`TLV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// extracted fields are zero unless the status says found
	`TLV_ASSERT_NOW(a_fields_zero, m_tvalid && m_tuser != tlv_cfe_pkg::ST_FOUND, m_tdata[71:0] == 72'd0, "fields set without extraction")

	// padding bits stay zero
	`TLV_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[95:92] == 4'd0, "tdata padding not zero")

	// a new result follows an input transfer through the input stage and output registers
	`TLV_ASSERT_NOW(a_result_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without a prior input transfer")

endmodule

bind tlv_chunk_field_extractor tlv_cfe_port_checker u_tlv_cfe_checker (.*);

[bench/tlv_cfe_checker.sv]
// result checker for the tlv chunk field extractor: tracks the chunk walk and compares results
`timescale 1ns / 1ps

module tlv_cfe_checker
	import tlv_cfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	output int                    pending,
	output int                    fail_count
);

	result_t due_results[$];

	// copy of the match register and of the search state
	logic [15:0]         want_kind;
	logic [15:0]         pos_in_chunk;
	logic [15:0]         chunk_len;
	logic [15:0]         chunk_kind;
	logic [POS_BITS-1:0] buf_pos;
	logic [15:0]         cap [4];
	logic [7:0]          cap_byte;
	logic [15:0]         sum_hi;
	logic [15:0]         sum_lo;
	logic                hit;
	logic                idle;

	function automatic logic [POS_BITS-1:0] clamp_pos(input logic [31:0] v);
		return (v > POS_MAX) ? POS_MAX : v[POS_BITS-1:0];
	endfunction

	task automatic clear_walk();
		pos_in_chunk = '0;
		chunk_len = '0;
		chunk_kind = '0;
		buf_pos = '0;
		foreach (cap[k])
			cap[k] = '0;
		cap_byte = '0;
		sum_hi = '0;
		sum_lo = '0;
		hit = 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("tb: mismatch in %s: got %0h, want %0h", what, got, want);
	endtask

	// one accepted byte of the buffer
	task automatic walk_byte(input logic [7:0] b, input logic st);
		int unsigned p;
		int unsigned ext;
		logic [31:0] base;
		logic        fire;
		result_t     r;
		if (st) begin
			clear_walk();
			idle = 1'b0;
		end else if (idle) begin
			return;
		end
		p = 32'(pos_in_chunk);
		base = (32'(buf_pos) >= p) ? 32'(buf_pos) - p : 32'd0;
		ext = 32'((chunk_kind == TYPE_A) ? EXTENT_A : EXTENT_B);
		fire = 1'b0;
		r = '0;
		if (p == 0) begin
			chunk_len = {b, 8'h00};
		end else if (p == 1) begin
			chunk_len[7:0] = b;
			if (chunk_len == 0) begin
				fire = 1'b1;
				r.status = ST_NOT_FOUND;
				r.next_offset = base[POS_BITS-1:0];
			end else if (chunk_len < 4) begin
				fire = 1'b1;
				r.status = ST_MALFORMED;
				r.next_offset = base[POS_BITS-1:0];
			end
		end else if (p == 2) begin
			chunk_kind = {b, 8'h00};
		end else if (p == 3) begin
			chunk_kind[7:0] = b;
			if (chunk_kind == want_kind) begin
				if (chunk_kind == TYPE_A || chunk_kind == TYPE_B) begin
					ext = 32'((chunk_kind == TYPE_A) ? EXTENT_A : EXTENT_B);
					if (chunk_len < ext) begin
						fire = 1'b1;
						r.status = ST_MALFORMED;
						r.next_offset = base[POS_BITS-1:0];
					end else begin
						hit = 1'b1;
					end
				end else begin
					fire = 1'b1;
					r.status = ST_NO_EXTRACT;
					r.next_offset = clamp_pos(base + 32'(chunk_len));
				end
			end
		end else if (hit) begin
			if (chunk_kind == TYPE_A) begin
				case (p)
					'h0E: cap[0][15:8] = b;
					'h0F: cap[0][7:0] = b;
					'h10: cap[1][15:8] = b;
					'h11: cap[1][7:0] = b;
					'h14, 'h16: sum_hi = sum_hi + 16'(b);
					'h15, 'h17: sum_lo = sum_lo + 16'(b);
					'h1A: cap[2][15:8] = b;
					'h1B: cap[2][7:0] = b;
					'h20: cap_byte = {7'b0, ~b[0]};
					default: ;
				endcase
				// high sum keeps its low byte only, low sum carry ors into bit 8
				cap[3] = {sum_hi[7:0], 8'h00} | sum_lo;
			end else begin
				case (p)
					'h04: cap[0][15:8] = b;
					'h05: cap[0][7:0] = b;
					'h06: cap[2][15:8] = b;
					'h07: cap[2][7:0] = b;
					'h0C: cap[1][15:8] = b;
					'h0D: cap[1][7:0] = b;
					'h0E: cap[3][15:8] = b;
					'h0F: cap[3][7:0] = b;
					'h15: cap_byte = b;
					default: ;
				endcase
			end
			if (p == ext - 1) begin
				fire = 1'b1;
				r.status = ST_FOUND;
				r.field_a = cap[0];
				r.field_b = cap[1];
				r.field_c = cap[2];
				r.extra_short = cap[3];
				r.extra_word = cap_byte;
				r.next_offset = clamp_pos(base + 32'(chunk_len));
			end
		end

		if (fire) begin
			idle = 1'b1;
		end else if (p >= 3 && p + 1 >= chunk_len) begin
			pos_in_chunk = '0;
			hit = 1'b0;
		end else begin
			pos_in_chunk = 16'(p + 1);
		end
		buf_pos = clamp_pos(32'(buf_pos) + 32'd1);
		if (fire)
			due_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t due;
		if (!arst_n) begin
			want_kind = '0;
			clear_walk();
			idle = 1'b1;
			due_results.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en)
				want_kind = cfg_wr_data;
			if (s_tvalid && s_tready)
				walk_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing due", 32'(m_tuser), 32'd0);
				end else begin
					due = due_results.pop_front();
					if (m_tuser !== due.status)
						flag_mismatch("status", 32'(m_tuser), 32'(due.status));
					if (m_tdata[15:0] !== due.field_a)
						flag_mismatch("field_a", 32'(m_tdata[15:0]), 32'(due.field_a));
					if (m_tdata[31:16] !== due.field_b)
						flag_mismatch("field_b", 32'(m_tdata[31:16]), 32'(due.field_b));
					if (m_tdata[47:32] !== due.field_c)
						flag_mismatch("field_c", 32'(m_tdata[47:32]), 32'(due.field_c));
					if (m_tdata[63:48] !== due.extra_short)
						flag_mismatch("extra_short", 32'(m_tdata[63:48]),
							32'(due.extra_short));
					if (m_tdata[71:64] !== due.extra_word)
						flag_mismatch("extra_word", 32'(m_tdata[71:64]),
							32'(due.extra_word));
					if (m_tdata[91:72] !== due.next_offset)
						flag_mismatch("next_offset", 32'(m_tdata[91:72]),
							32'(due.next_offset));
					if (m_tdata[95:92] !== 4'h0)
						flag_mismatch("pad bits", 32'(m_tdata[95:92]), 32'd0);
				end
			end
			pending = due_results.size();
		end
	end

endmodule

[bench/tlv_chunk_field_extractor_tb.sv]
// testbench top for the tlv chunk field extractor: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tlv_chunk_field_extractor_tb;
	import tlv_cfe_pkg::*;

	logic                  clk;
	logic                  arst_n = 1'b0;

	// byte channel into the block
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] byte_value
	logic                  s_tuser = 1'b0; // [0] start_of_buffer

	// result channel out of the block
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // a, b, c, extra_short, extra_word, next_offset
	logic [1:0]            m_tuser;        // [1:0] status

	logic                  cfg_wr_en = 1'b0;
	logic [15:0]           cfg_wr_data = '0;

	int                    pending;
	int                    fail_count;

	// idling knobs, in percent of cycles
	int                    idle_pct = 0;
	int                    stall_pct = 0;

	// long receiver hold-off, requested by the stimulus and counted by the receiver
	logic                  hold_req = 1'b0;
	logic                  hold_taken = 1'b0;
	int                    hold_left = 0;

	logic                  lead = 1'b0;    // next byte opens a new search
	logic [15:0]           match_now = '0; // what the match register holds
	int                    sent = 0;

	tlv_chunk_field_extractor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	tlv_cfe_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, or a long hold-off once asked for
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// one byte transfer, with random idle cycles ahead of it
	task automatic push_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// byte of the current search; the first one carries the start flag
	task automatic put(input logic [7:0] b);
		push_byte(b, lead);
		lead = 1'b0;
	endtask

	// chunk header plus nbody body bytes; fill < 0 gives random body bytes
	task automatic put_chunk(input logic [15:0] len, input logic [15:0] kind,
			input int nbody, input int fill);
		logic [7:0] v;
		put(len[15:8]);
		put(len[7:0]);
		put(kind[15:8]);
		put(kind[7:0]);
		for (int i = 0; i < nbody; i++) begin
			v = (fill < 0) ? 8'($urandom) : 8'(fill);
			put(v);
		end
	endtask

	function automatic int body_fill();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 80)
			return -1;
		return (roll < 90) ? 255 : 0;
	endfunction

	function automatic logic [15:0] pick_match();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 30)
			return TYPE_A;
		if (roll < 60)
			return TYPE_B;
		if (roll < 70)
			return 16'h0000;
		if (roll < 80)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// stop sending, let every due result drain, then cover the pipeline depth
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// match register is only written with the block idle
	task automatic set_match(input logic [15:0] v);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		match_now = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one random search: stray bytes, or up to three skipped chunks and then an ending of some kind
	task automatic random_search();
		int          roll;
		int          ext;
		int          nbody;
		logic [15:0] len;
		logic [15:0] kind;
		roll = $urandom_range(99, 0);
		if (roll < 8) begin
			// stray bytes, start flag at random
			repeat ($urandom_range(6, 1))
				push_byte(8'($urandom), 1'($urandom_range(1, 0)));
			return;
		end
		lead = 1'b1;
		repeat ($urandom_range(3, 0)) begin
			kind = 16'($urandom);
			if ($urandom_range(4, 0) == 0)
				kind = $urandom_range(1, 0) ? TYPE_A : TYPE_B;
			if (kind == match_now)
				kind ^= 16'h0100;
			len = ($urandom_range(99, 0) < 85) ? 16'($urandom_range(24, 4))
				: 16'($urandom_range(70, 25));
			put_chunk(len, kind, int'(len) - 4, body_fill());
		end
		ext = int'((match_now == TYPE_A) ? EXTENT_A : EXTENT_B);
		roll = $urandom_range(99, 0);
		if (roll < 45) begin
			if (match_now == TYPE_A || match_now == TYPE_B) begin
				if ($urandom_range(3, 0) == 0) begin
					// too short for its extraction extent
					len = 16'($urandom_range(ext - 1, 4));
					nbody = int'(len) - 4;
				end else begin
					len = ($urandom_range(9, 0) == 0) ? 16'hFFFF
						: 16'($urandom_range(ext + 12, ext));
					nbody = ext - 4 + int'($urandom_range(2, 0));
				end
			end else begin
				len = 16'($urandom_range(40, 4));
				nbody = int'($urandom_range(3, 0));
			end
			put_chunk(len, match_now, nbody, body_fill());
		end else if (roll < 65) begin
			put(8'h00);
			put(8'h00);
		end else if (roll < 78) begin
			put(8'h00);
			put(8'($urandom_range(3, 1)));
		end else if (roll < 90) begin
			// buffer cut off inside a chunk, the next search starts over
			kind = $urandom_range(1, 0) ? match_now : 16'($urandom);
			put_chunk(16'($urandom_range(60, 8)), kind, int'($urandom_range(12, 0)),
				body_fill());
		end else begin
			// terminator, then trailing bytes the block must ignore
			put(8'h00);
			put(8'h00);
			repeat ($urandom_range(4, 1))
				push_byte(8'($urandom), 1'b0);
		end
	endtask

	initial begin : stimulus
		int idle_tab [4] = '{0, 77, 0, 24};
		int stall_tab [4] = '{0, 0, 77, 24};
		int n;
		int mark;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any start are dropped
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		// zero-length terminator right away
		lead = 1'b1;
		put(8'h00);
		put(8'h00);
		// length one, then bytes after the result that must be ignored
		lead = 1'b1;
		put(8'h00);
		put(8'h01);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		// length three
		lead = 1'b1;
		put(8'h00);
		put(8'h03);
		// type 0 matches the reset value of the register, no extraction
		lead = 1'b1;
		put_chunk(16'd4, 16'h0000, 0, 0);

		set_match(TYPE_A);
		// skip one chunk, then a type 2 chunk one byte short
		lead = 1'b1;
		put_chunk(16'd6, 16'h0005, 2, -1);
		put_chunk(EXTENT_A - 16'd1, TYPE_A, 0, 0);
		// all-ones body: byte sums overflow, inverted flag bit is zero
		lead = 1'b1;
		put_chunk(EXTENT_A, TYPE_A, int'(EXTENT_A) - 4, 255);
		// longest length, all-zero body
		lead = 1'b1;
		put_chunk(16'hFFFF, TYPE_A, int'(EXTENT_A) - 4, 0);
		// search cut off mid-chunk, then a fresh one over an unmatched type 7
		lead = 1'b1;
		put_chunk(16'd16, 16'h0009, 5, -1);
		lead = 1'b1;
		put_chunk(16'd4, TYPE_B, 0, 0);
		put(8'h00);
		put(8'h00);

		set_match(TYPE_B);
		lead = 1'b1;
		put_chunk(EXTENT_B - 16'd1, TYPE_B, 0, 0);
		lead = 1'b1;
		put_chunk(16'd8, TYPE_A, 4, -1);
		put_chunk(EXTENT_B, TYPE_B, int'(EXTENT_B) - 4, 255);
		lead = 1'b1;
		put_chunk(16'hFFFF, TYPE_B, int'(EXTENT_B) - 4, -1);

		set_match(16'hFFFF);
		lead = 1'b1;
		put_chunk(16'hFFFF, 16'hFFFF, 0, 0);

		// random searches under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			set_match(pick_match());
			if (ph == 0) begin
				// receiver holds off while short searches keep coming, so the input backs up
				hold_req = 1'b1;
				repeat (30) begin
					lead = 1'b1;
					put(8'h00);
					put(8'h00);
				end
			end
			n = 0;
			mark = sent;
			while (sent - mark < 300) begin
				random_search();
				n++;
				if (n % 8 == 0)
					set_match(pick_match());
			end
		end

		quiesce();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
